>>> design/baudot_pkg.sv
// ----------------------------------------------------------------------------
// baudot_pkg
// Shared types, ITA2 code constants and character lookup functions for the
// RTTY transmit encoder.
// ----------------------------------------------------------------------------
package baudot_pkg;

  localparam int CodeWidth  = 5;
  localparam int FreqWidth  = 32;
  localparam int OffsWidth  = 16;
  localparam int CharWidth  = 8;
  localparam int FrameBits  = 7;

  typedef logic [CodeWidth-1:0] code_t;
  typedef logic [FreqWidth-1:0] freq_t;
  typedef logic [OffsWidth-1:0] offs_t;
  typedef logic [CharWidth-1:0] char_t;

  // ITA2 control codes
  localparam code_t CODE_LTRS = 5'd31;
  localparam code_t CODE_FIGS = 5'd27;
  localparam code_t CODE_LF   = 5'd2;
  localparam code_t CODE_CR   = 5'd8;
  localparam code_t CODE_NULL = 5'd0;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_BASE_FREQUENCY = 1'b0,
    REG_MARK_OFFSET    = 1'b1
  } reg_index_t;

  // one frame request: an optional shift frame followed by a character frame
  typedef struct packed {
    logic  two_frames;
    code_t shift_code;
    code_t char_code;
  } frame_req_t;

  // upper-case letter to letters-table code
  function automatic code_t letter_code(input char_t ch);
    code_t c;
    case (ch)
      "E": c = 5'd1;   "A": c = 5'd3;   "S": c = 5'd5;   "I": c = 5'd6;
      "U": c = 5'd7;   "D": c = 5'd9;   "R": c = 5'd10;  "J": c = 5'd11;
      "N": c = 5'd12;  "F": c = 5'd13;  "C": c = 5'd14;  "K": c = 5'd15;
      "T": c = 5'd16;  "Z": c = 5'd17;  "L": c = 5'd18;  "W": c = 5'd19;
      "H": c = 5'd20;  "Y": c = 5'd21;  "P": c = 5'd22;  "Q": c = 5'd23;
      "O": c = 5'd24;  "B": c = 5'd25;  "G": c = 5'd26;  "M": c = 5'd28;
      "X": c = 5'd29;  "V": c = 5'd30;
      default: c = CODE_NULL;
    endcase
    return c;
  endfunction

  // character to figures-table code, null when not found
  function automatic code_t figure_code(input char_t ch);
    code_t c;
    case (ch)
      "3": c = 5'd1;   8'h0a: c = 5'd2; "-": c = 5'd3;   " ": c = 5'd4;
      8'h07: c = 5'd5; "8": c = 5'd6;   "7": c = 5'd7;   8'h0d: c = 5'd8;
      "$": c = 5'd9;   "4": c = 5'd10;  8'h27: c = 5'd11; ",": c = 5'd12;
      "!": c = 5'd13;  ":": c = 5'd14;  "(": c = 5'd15;  "5": c = 5'd16;
      8'h22: c = 5'd17; ")": c = 5'd18; "2": c = 5'd19;  "#": c = 5'd20;
      "6": c = 5'd21;  "0": c = 5'd22;  "1": c = 5'd23;  "9": c = 5'd24;
      "?": c = 5'd25;  "&": c = 5'd26;  ".": c = 5'd28;  "/": c = 5'd29;
      ";": c = 5'd30;
      default: c = CODE_NULL;
    endcase
    return c;
  endfunction

endpackage

>>> design/baudot_front.sv
// ----------------------------------------------------------------------------
// baudot_front
// Accepts characters, tracks the letters/figures shift and turns each
// character into a frame request for the serializer.
// ----------------------------------------------------------------------------
module baudot_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  baudot_pkg::char_t      character,
  input  logic                   message_start,
  output logic                   push,
  output baudot_pkg::frame_req_t push_req,
  input  logic                   queue_full
);
  import baudot_pkg::*;

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_LETTERS = 2'd1,
    MODE_FIGURES = 2'd2
  } mode_t;

  mode_t      mode;
  mode_t      mode_next;
  mode_t      eff_mode;
  logic       is_upper;
  logic       is_lower;
  char_t      upper_ch;
  code_t      fig_code;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // classify the character
  always_comb begin
    eff_mode  = message_start ? MODE_NONE : mode;
    is_upper  = (character >= "A") && (character <= "Z");
    is_lower  = (character >= "a") && (character <= "z");
    upper_ch  = is_lower ? (character - 8'd32) : character;
    fig_code  = figure_code(character);
    mode_next = eff_mode;
    push_req  = '{two_frames: 1'b0, shift_code: CODE_NULL, char_code: CODE_NULL};
    if (character == 8'h0a) begin
      push_req.char_code = CODE_LF;
    end else if (character == 8'h0d) begin
      push_req.char_code = CODE_CR;
    end else if (is_upper || is_lower) begin
      push_req.char_code = letter_code(upper_ch);
      if (eff_mode != MODE_LETTERS) begin
        push_req.two_frames = 1'b1;
        push_req.shift_code = CODE_LTRS;
      end
      mode_next = MODE_LETTERS;
    end else begin
      push_req.char_code = fig_code;
      if (fig_code != CODE_NULL) begin
        if (eff_mode != MODE_FIGURES) begin
          push_req.two_frames = 1'b1;
          push_req.shift_code = CODE_FIGS;
        end
        mode_next = MODE_FIGURES;
      end
    end
  end

  // shift mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NONE;
    end else if (push) begin
      mode <= mode_next;
    end
  end

endmodule

>>> design/baudot_queue.sv
// ----------------------------------------------------------------------------
// baudot_queue
// Two-entry queue of frame requests between the front and the serializer.
// ----------------------------------------------------------------------------
module baudot_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  baudot_pkg::frame_req_t push_req,
  output logic                   full,
  input  logic                   pop,
  output logic                   head_valid,
  output baudot_pkg::frame_req_t head_req
);
  import baudot_pkg::*;

  frame_req_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_req   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/baudot_back.sv
// ----------------------------------------------------------------------------
// baudot_back
// Serializes frame requests into start, five data and stop bits, one bit per
// cycle unless stalled, with each bit's tone frequency in an output register.
// ----------------------------------------------------------------------------
module baudot_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  baudot_pkg::frame_req_t head_req,
  output logic                   pop,
  input  baudot_pkg::freq_t      base_frequency,
  input  baudot_pkg::offs_t      mark_offset,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   line_bit,
  output baudot_pkg::freq_t      tone_frequency,
  output logic                   last_bit
);
  import baudot_pkg::*;

  logic [2:0] bit_idx;
  logic       frame_sel;
  logic       advance;
  logic       last_frame;
  code_t      cur_code;
  logic       cur_bit;

  assign advance    = head_valid && (!out_valid || !out_stall);
  assign last_frame = !head_req.two_frames || frame_sel;
  assign cur_code   = last_frame ? head_req.char_code : head_req.shift_code;
  assign pop        = advance && last_frame && (bit_idx == 3'd6);

  // pick the line bit of the current position in the frame
  always_comb begin
    case (bit_idx)
      3'd0:    cur_bit = 1'b0;
      3'd1:    cur_bit = cur_code[0];
      3'd2:    cur_bit = cur_code[1];
      3'd3:    cur_bit = cur_code[2];
      3'd4:    cur_bit = cur_code[3];
      3'd5:    cur_bit = cur_code[4];
      default: cur_bit = 1'b1;
    endcase
  end

  // bit and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_idx   <= 3'd0;
      frame_sel <= 1'b0;
    end else if (advance) begin
      if (bit_idx == 3'd6) begin
        bit_idx   <= 3'd0;
        frame_sel <= !last_frame;
      end else begin
        bit_idx <= bit_idx + 3'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      line_bit       <= cur_bit;
      tone_frequency <= base_frequency + (cur_bit ? {16'd0, mark_offset} : '0);
      last_bit       <= last_frame && (bit_idx == 3'd6);
    end
  end

endmodule

>>> design/baudot_rtty_transmit_encoder.sv
// ----------------------------------------------------------------------------
// baudot_rtty_transmit_encoder
// ITA2 RTTY transmit encoder: ASCII characters in, framed line bits with
// their mark/space tone frequency out.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------
//  config   | cfg_we              | cfg_index, cfg_data
//  input    | in_valid / in_stall | character, message_start
//  output   | out_valid/out_stall | line_bit, tone_frequency, last_bit
//
// Each character gives 7 or 14 line bits, one per cycle unless the output
// stalls. A two-entry request queue lets the next characters be accepted
// while bits still go out. Reset (synchronous) clears the shift mode to
// none, empties the queue and loads the default tone registers. An output
// stall holds the serializer.
// ----------------------------------------------------------------------------
module baudot_rtty_transmit_encoder (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  baudot_pkg::char_t       character,
  input  logic                    message_start,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    line_bit,
  output baudot_pkg::freq_t       tone_frequency,
  output logic                    last_bit
);
  import baudot_pkg::*;

  freq_t      base_frequency;
  offs_t      mark_offset;
  logic       push;
  frame_req_t push_req;
  logic       queue_full;
  logic       pop;
  logic       head_valid;
  frame_req_t head_req;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_frequency <= 32'd14510000;
      mark_offset    <= 16'd17;
    end else if (cfg_we) begin
      if (cfg_index == REG_BASE_FREQUENCY) begin
        base_frequency <= cfg_data;
      end else begin
        mark_offset <= cfg_data[15:0];
      end
    end
  end

  baudot_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .character     (character),
    .message_start (message_start),
    .push          (push),
    .push_req      (push_req),
    .queue_full    (queue_full)
  );

  baudot_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_req   (push_req),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

  baudot_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_req       (head_req),
    .pop            (pop),
    .base_frequency (base_frequency),
    .mark_offset    (mark_offset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .line_bit       (line_bit),
    .tone_frequency (tone_frequency),
    .last_bit       (last_bit)
  );

endmodule
